// ----- hw/rtl/rmv_pkg.sv -----
// rmv_pkg: shared constants, command and status types for the running mean/variance block
// no dependencies; used by every module under hw/rtl
package rmv_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 24;
  localparam int FRAC_BITS_DEF   = 8;

  localparam int AXES    = 3;
  localparam int AXIS_W  = 2;
  localparam int MUL_DIG = 8;   // multiplier digit width, bits per cycle

  typedef logic [AXIS_W-1:0] axis_t;

  localparam axis_t AXIS_LAST = axis_t'(AXES - 1);

  // operand selection for the shared multiplier
  typedef enum logic [1:0] {
    MUL_NN,
    MUL_SQ,
    MUL_NSQ
  } mul_sel_t;

  typedef struct packed {
    logic     take_in;
    logic     acc_en;
    axis_t    axis;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     div_start;
    logic     div_mean;
    logic     cap_nn;
    logic     cap_ssq;
    logic     cap_mean;
    logic     cap_spread;
    logic     load_out;
  } rmv_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
  } rmv_sts_t;

endpackage

// ----- hw/rtl/rmv_mul.sv -----
// rmv_mul: digit-serial unsigned multiplier, MUL_DIG bits of b per cycle, msb digit first
// depends on rmv_pkg
module rmv_mul import rmv_pkg::*; #(
  parameter int A_W = 2 * SAMPLE_BITS_DEF + COUNT_BITS_DEF - 2,
  parameter int B_W = SAMPLE_BITS_DEF + COUNT_BITS_DEF - 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               busy,
  output logic [A_W+B_W-1:0] prod
);

  localparam int ND    = (B_W + MUL_DIG - 1) / MUL_DIG;
  localparam int BP_W  = ND * MUL_DIG;
  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(ND + 1);

  logic               busy_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [A_W-1:0]     a_r;
  logic [BP_W-1:0]    b_r;
  logic [P_W-1:0]     acc_r;
  logic [P_W-1:0]     acc_nxt;
  logic [MUL_DIG-1:0] dig;
  logic [A_W+MUL_DIG-1:0] part;

  always_comb begin
    dig     = b_r[BP_W-1 -: MUL_DIG];
    part    = (A_W + MUL_DIG)'(a_r) * (A_W + MUL_DIG)'(dig);
    acc_nxt = (acc_r << MUL_DIG) + P_W'(part);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(ND);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= BP_W'(b);
      acc_r <= '0;
    end else if (busy_r) begin
      b_r   <= b_r << MUL_DIG;
      acc_r <= acc_nxt;
    end
  end

  assign busy = busy_r;
  assign prod = acc_r;

endmodule

// ----- hw/rtl/rmv_div.sv -----
// rmv_div: restoring radix-2 divider, one quotient bit per cycle, step count per job
// depends on rmv_pkg; the caller preloads the high remainder so only quotient bits iterate
module rmv_div import rmv_pkg::*; #(
  parameter int DV_W = 2 * COUNT_BITS_DEF,
  parameter int Q_W  = 2 * SAMPLE_BITS_DEF + FRAC_BITS_DEF - 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DV_W-1:0]          divisor,
  input  logic [DV_W-1:0]          rem_init,
  input  logic [Q_W-1:0]           lo_init,
  input  logic [$clog2(Q_W+1)-1:0] steps,
  output logic                     busy,
  output logic [Q_W-1:0]           quo
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DV_W-1:0]  dvs_r;
  logic [DV_W-1:0]  rem_r;
  logic [DV_W-1:0]  rem_nxt;
  logic [Q_W-1:0]   lo_r;
  logic [Q_W-1:0]   quo_r;
  logic [DV_W:0]    cat;
  logic [DV_W+1:0]  diff;
  logic             qbit;

  always_comb begin
    cat     = {rem_r, lo_r[Q_W-1]};
    diff    = {1'b0, cat} - {2'b00, dvs_r};
    qbit    = !diff[DV_W+1];
    rem_nxt = qbit ? diff[DV_W-1:0] : cat[DV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
      rem_r <= rem_init;
      lo_r  <= lo_init;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_r << 1;
      quo_r <= {quo_r[Q_W-2:0], qbit};
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

// ----- hw/rtl/rmv_datapath.sv -----
// rmv_datapath: sample count, per-axis sums and sums of squares, shared multiplier and divider,
// result staging and output registers; depends on rmv_pkg, rmv_mul, rmv_div
module rmv_datapath import rmv_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rmv_cmd_t                             cmd,
  output rmv_sts_t                             sts,
  input  logic signed [SAMPLE_BITS-1:0]        accel_x,
  input  logic signed [SAMPLE_BITS-1:0]        accel_y,
  input  logic signed [SAMPLE_BITS-1:0]        accel_z,
  output logic signed [SAMPLE_BITS+FRAC_BITS-1:0] mean_x,
  output logic signed [SAMPLE_BITS+FRAC_BITS-1:0] mean_y,
  output logic signed [SAMPLE_BITS+FRAC_BITS-1:0] mean_z,
  output logic [2*SAMPLE_BITS+FRAC_BITS-2:0]   spread_x,
  output logic [2*SAMPLE_BITS+FRAC_BITS-2:0]   spread_y,
  output logic [2*SAMPLE_BITS+FRAC_BITS-2:0]   spread_z,
  output logic [COUNT_BITS-1:0]                sample_total,
  output logic                                 saturated
);

  localparam int S        = SAMPLE_BITS;
  localparam int C        = COUNT_BITS;
  localparam int SUM_W    = S + C;
  localparam int MAG_W    = S + C - 1;
  localparam int SQ_W     = 2 * S + C - 2;
  localparam int MEAN_W   = S + FRAC_BITS;
  localparam int SPREAD_W = 2 * S + FRAC_BITS - 1;
  localparam int NN_W     = 2 * C;
  localparam int NUM0_W   = 2 * MAG_W;
  localparam int NUM_W    = NUM0_W + FRAC_BITS;
  localparam int DMEAN_W  = MAG_W + FRAC_BITS;
  localparam int MA_W     = SQ_W;
  localparam int MB_W     = MAG_W;
  localparam int MP_W     = MA_W + MB_W;
  localparam int DV_W     = NN_W;
  localparam int Q_W      = SPREAD_W;
  localparam int DCNT_W   = $clog2(Q_W + 1);

  // accumulated state
  logic [C-1:0]            count_r;
  logic                    full_r;
  logic signed [SUM_W-1:0] sum_r [AXES];
  logic [SQ_W-1:0]         sq_r  [AXES];
  logic signed [S-1:0]     smp_r [AXES];

  // intermediate products and staged results
  logic [NN_W-1:0]     nn_r;
  logic [NUM0_W-1:0]   ssq_r;
  logic [MEAN_W-1:0]   mean_res_r [AXES];
  logic [SPREAD_W-1:0] spr_res_r  [AXES];
  logic [MEAN_W-1:0]   out_mean_r [AXES];
  logic [SPREAD_W-1:0] out_spr_r  [AXES];
  logic [C-1:0]        out_total_r;
  logic                out_sat_r;

  logic signed [SUM_W-1:0] sel_sum;
  logic [SUM_W-1:0]        neg_sum;
  logic [MAG_W-1:0]        mag;
  logic signed [S-1:0]     sel_smp;
  logic signed [2*S-1:0]   smp_sq;

  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [MP_W-1:0] mul_prod;
  logic            mul_busy;

  logic [DMEAN_W-1:0] dm;
  logic [NUM0_W:0]    num0_full;
  logic [NUM0_W-1:0]  num0;
  logic [NUM_W-1:0]   dn;
  logic [DV_W-1:0]    div_dvs;
  logic [DV_W-1:0]    div_rem0;
  logic [Q_W-1:0]     div_lo0;
  logic [DCNT_W-1:0]  div_steps;
  logic [Q_W-1:0]     div_quo;
  logic               div_busy;
  logic [MEAN_W-1:0]  q_mean;
  logic [MEAN_W-1:0]  mean_val;

  always_comb begin
    sel_sum = sum_r[cmd.axis];
    neg_sum = -sel_sum;
    mag     = sel_sum[SUM_W-1] ? neg_sum[MAG_W-1:0] : sel_sum[MAG_W-1:0];
    sel_smp = smp_r[cmd.axis];
    smp_sq  = sel_smp * sel_smp;
  end

  // multiplier operand selection
  always_comb begin
    case (cmd.mul_sel)
      MUL_NN: begin
        mul_a = MA_W'(count_r);
        mul_b = MB_W'(count_r);
      end
      MUL_SQ: begin
        mul_a = MA_W'(mag);
        mul_b = mag;
      end
      MUL_NSQ: begin
        mul_a = sq_r[cmd.axis];
        mul_b = MB_W'(count_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider job setup: high part of the dividend goes straight into the remainder
  always_comb begin
    dm        = DMEAN_W'(mag) << FRAC_BITS;
    num0_full = {1'b0, mul_prod[NUM0_W-1:0]} - {1'b0, ssq_r};
    num0      = num0_full[NUM0_W] ? '0 : num0_full[NUM0_W-1:0];
    dn        = NUM_W'(num0) << FRAC_BITS;
    if (cmd.div_mean) begin
      div_dvs   = DV_W'(count_r);
      div_rem0  = DV_W'(dm >> MEAN_W);
      div_lo0   = Q_W'(dm[MEAN_W-1:0]) << (Q_W - MEAN_W);
      div_steps = DCNT_W'(MEAN_W);
    end else begin
      div_dvs   = nn_r;
      div_rem0  = DV_W'(dn >> Q_W);
      div_lo0   = dn[Q_W-1:0];
      div_steps = DCNT_W'(Q_W);
    end
    q_mean   = div_quo[MEAN_W-1:0];
    mean_val = sel_sum[SUM_W-1] ? -q_mean : q_mean;
  end

  rmv_mul #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .prod  (mul_prod)
  );

  rmv_div #(
    .DV_W (DV_W),
    .Q_W  (Q_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .divisor  (div_dvs),
    .rem_init (div_rem0),
    .lo_init  (div_lo0),
    .steps    (div_steps),
    .busy     (div_busy),
    .quo      (div_quo)
  );

  // statistics state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      full_r  <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        sum_r[a] <= '0;
        sq_r[a]  <= '0;
      end
    end else begin
      if (cmd.take_in) begin
        full_r <= &count_r;
        if (!(&count_r)) begin
          count_r <= count_r + 1'b1;
        end
      end
      if (cmd.acc_en && !full_r) begin
        sum_r[cmd.axis] <= sel_sum + SUM_W'(sel_smp);
        sq_r[cmd.axis]  <= sq_r[cmd.axis] + SQ_W'($unsigned(smp_sq));
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      smp_r[0] <= accel_x;
      smp_r[1] <= accel_y;
      smp_r[2] <= accel_z;
    end
    if (cmd.cap_nn) begin
      nn_r <= mul_prod[NN_W-1:0];
    end
    if (cmd.cap_ssq) begin
      ssq_r <= mul_prod[NUM0_W-1:0];
    end
    if (cmd.cap_mean) begin
      mean_res_r[cmd.axis] <= mean_val;
    end
    if (cmd.cap_spread) begin
      spr_res_r[cmd.axis] <= div_quo;
    end
    if (cmd.load_out) begin
      for (int a = 0; a < AXES; a++) begin
        out_mean_r[a] <= mean_res_r[a];
        out_spr_r[a]  <= spr_res_r[a];
      end
      out_total_r <= count_r;
      out_sat_r   <= full_r;
    end
  end

  assign sts.mul_busy = mul_busy;
  assign sts.div_busy = div_busy;

  assign mean_x       = $signed(out_mean_r[0]);
  assign mean_y       = $signed(out_mean_r[1]);
  assign mean_z       = $signed(out_mean_r[2]);
  assign spread_x     = out_spr_r[0];
  assign spread_y     = out_spr_r[1];
  assign spread_z     = out_spr_r[2];
  assign sample_total = out_total_r;
  assign saturated    = out_sat_r;

endmodule

// ----- hw/rtl/rmv_ctrl.sv -----
// rmv_ctrl: sequencer for one request: n*n multiply, then per axis accumulate, mean divide,
// two multiplies and spread divide; owns the stream handshakes; depends on rmv_pkg
module rmv_ctrl import rmv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output rmv_cmd_t cmd,
  input  rmv_sts_t sts
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_NN   = 8'b0000_0010,
    S_ACC  = 8'b0000_0100,
    S_MEAN = 8'b0000_1000,
    S_SQ   = 8'b0001_0000,
    S_NSQ  = 8'b0010_0000,
    S_SPR  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;      // unit start still to be issued in this state
  axis_t  axis_r, axis_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.axis      = axis_r;
    cmd.mul_sel   = MUL_NN;
    in_tready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take_in = 1'b1;
          state_nxt   = S_NN;
          pend_nxt    = 1'b1;
          axis_nxt    = '0;
        end
      end
      S_NN: begin
        cmd.mul_sel = MUL_NN;
        if (pend_r) begin
          cmd.mul_start = 1'b1;
          pend_nxt      = 1'b0;
        end else if (!sts.mul_busy) begin
          cmd.cap_nn = 1'b1;
          state_nxt  = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        state_nxt  = S_MEAN;
        pend_nxt   = 1'b1;
      end
      S_MEAN: begin
        cmd.div_mean = 1'b1;
        if (pend_r) begin
          cmd.div_start = 1'b1;
          pend_nxt      = 1'b0;
        end else if (!sts.div_busy) begin
          cmd.cap_mean = 1'b1;
          state_nxt    = S_SQ;
          pend_nxt     = 1'b1;
        end
      end
      S_SQ: begin
        cmd.mul_sel = MUL_SQ;
        if (pend_r) begin
          cmd.mul_start = 1'b1;
          pend_nxt      = 1'b0;
        end else if (!sts.mul_busy) begin
          cmd.cap_ssq = 1'b1;
          state_nxt   = S_NSQ;
          pend_nxt    = 1'b1;
        end
      end
      S_NSQ: begin
        cmd.mul_sel = MUL_NSQ;
        if (pend_r) begin
          cmd.mul_start = 1'b1;
          pend_nxt      = 1'b0;
        end else if (!sts.mul_busy) begin
          state_nxt = S_SPR;
          pend_nxt  = 1'b1;
        end
      end
      S_SPR: begin
        if (pend_r) begin
          cmd.div_start = 1'b1;
          pend_nxt      = 1'b0;
        end else if (!sts.div_busy) begin
          cmd.cap_spread = 1'b1;
          if (axis_r == AXIS_LAST) begin
            state_nxt = S_OUT;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            state_nxt = S_ACC;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        pend_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

`ifndef SYNTHESIS
  a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(sts.mul_busy || sts.div_busy))
    else $error("request taken while a unit is still busy");

  a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |-> !sts.mul_busy)
    else $error("multiplier restarted while busy");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider restarted while busy");

  a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_tvalid)
    else $error("result loaded but not presented");

  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    axis_r <= AXIS_LAST)
    else $error("axis index out of range");
`endif

endmodule

// ----- hw/rtl/running_mean_variance_3axis.sv -----
// running_mean_variance_3axis: top level, running mean and population variance of three axes
// depends on rmv_pkg, rmv_ctrl, rmv_datapath (which holds rmv_mul and rmv_div)
//
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    in_tdata: accel_x, accel_y, accel_z
// out_     out  out_tvalid/out_tready  out_tdata: means, spreads, count; out_tuser: saturated
//
// the one-bit-per-cycle divider is shared by all six quotients, and the 8-bit-digit
//   multiplier is shared by n*n, sum^2 and n*sumsq
// reset clears count, sums and sums of squares; no clearing pass
// a new request is taken while the previous result waits in the output register;
//   the block stalls before loading a result only if the previous one is still not taken
module running_mean_variance_3axis import rmv_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // accel_x, accel_y, accel_z, zero pad to whole bytes
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // mean_x, mean_y, mean_z, spread_x, spread_y, spread_z, sample_total, zero pad
  output logic [((3*(SAMPLE_BITS+FRAC_BITS)+3*(2*SAMPLE_BITS+FRAC_BITS-1)+COUNT_BITS+7)/8)*8-1:0]
               out_tdata,
  // saturated
  output logic out_tuser
);

  localparam int S        = SAMPLE_BITS;
  localparam int MEAN_W   = SAMPLE_BITS + FRAC_BITS;
  localparam int SPREAD_W = 2 * SAMPLE_BITS + FRAC_BITS - 1;
  localparam int OUT_W    = 3 * MEAN_W + 3 * SPREAD_W + COUNT_BITS;
  localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8;

  rmv_cmd_t cmd;
  rmv_sts_t sts;

  logic signed [MEAN_W-1:0] mean_x, mean_y, mean_z;
  logic [SPREAD_W-1:0]      spread_x, spread_y, spread_z;
  logic [COUNT_BITS-1:0]    sample_total;
  logic                     saturated;

  // sequencer: handshakes and command stream
  rmv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // accumulators, arithmetic units and result registers
  rmv_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .accel_x      ($signed(in_tdata[S-1:0])),
    .accel_y      ($signed(in_tdata[2*S-1:S])),
    .accel_z      ($signed(in_tdata[3*S-1:2*S])),
    .mean_x       (mean_x),
    .mean_y       (mean_y),
    .mean_z       (mean_z),
    .spread_x     (spread_x),
    .spread_y     (spread_y),
    .spread_z     (spread_z),
    .sample_total (sample_total),
    .saturated    (saturated)
  );

  // fields packed from bit 0 up, zero filled to the byte boundary
  assign out_tdata = OUT_TD_W'({sample_total, spread_z, spread_y, spread_x,
                                mean_z, mean_y, mean_x});
  assign out_tuser = saturated;

endmodule

// ----- tb/testbench.sv -----
// testbench: running mean and population variance of three axes, streaming in and out
// depends on rmv_pkg and running_mean_variance_3axis; a scoreboard class predicts each result
module testbench import rmv_pkg::*;;

  localparam int SB       = SAMPLE_BITS_DEF;
  localparam int CB       = COUNT_BITS_DEF;
  localparam int FB       = FRAC_BITS_DEF;
  localparam int MEAN_W   = SB + FB;
  localparam int SPREAD_W = 2 * SB + FB - 1;
  localparam int IN_W     = ((3 * SB + 7) / 8) * 8;
  localparam int OUT_W    = ((3 * MEAN_W + 3 * SPREAD_W + CB + 7) / 8) * 8;
  localparam int SPREAD_LO = 3 * MEAN_W;
  localparam int TOTAL_LO  = 3 * MEAN_W + 3 * SPREAD_W;
  localparam logic [CB-1:0] COUNT_FULL = {CB{1'b1}};

  localparam int RANDOM_ITEMS = 430;
  localparam int HOLD_CYCLES  = 600;   // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES = 300;   // extra wait for any late result
  localparam int STALL_LIMIT  = 4000;  // cycles with no handshake before giving up

  typedef struct packed {
    logic [AXES-1:0][MEAN_W-1:0]   mean;
    logic [AXES-1:0][SPREAD_W-1:0] spread;
    logic [CB-1:0]                 total;
    logic                          saturated;
  } stats_t;

  // running sums per axis, the shared count and the queue of expected statistics
  class moment_tracker;
    logic [CB-1:0]   count;
    longint          axis_sum [AXES];
    logic [63:0]     axis_sq_sum [AXES];
    stats_t          pending_stats [$];
    int              mismatches;
    int              matched;

    function new();
      count = '0;
      for (int a = 0; a < AXES; a++) begin
        axis_sum[a]    = 0;
        axis_sq_sum[a] = '0;
      end
      mismatches = 0;
      matched    = 0;
    endfunction

    function int pending();
      return pending_stats.size();
    endfunction

    // fold one request into the sums and queue the statistics it should produce
    function void fold_sample(logic [IN_W-1:0] data);
      stats_t          exp_stats;
      logic signed [SB-1:0] s;
      longint          n_s;
      longint          q;
      logic [63:0]     mag;
      logic [127:0]    nsq;
      logic [127:0]    ssq;
      logic [127:0]    num;
      logic [127:0]    den;
      logic [127:0]    spread;
      logic            full;
      full = (count == COUNT_FULL);
      // a full count drops the sample and reports what is held
      if (!full) begin
        for (int a = 0; a < AXES; a++) begin
          s = data[a*SB +: SB];
          axis_sum[a]    = axis_sum[a] + longint'(s);
          axis_sq_sum[a] = axis_sq_sum[a] + 64'(longint'(s) * longint'(s));
        end
        count = count + 1'b1;
      end
      n_s = longint'(count);
      for (int a = 0; a < AXES; a++) begin
        if (count == '0) begin
          exp_stats.mean[a]   = '0;
          exp_stats.spread[a] = '0;
        end else begin
          // signed division truncates toward zero
          q   = (axis_sum[a] * (longint'(1) << FB)) / n_s;
          mag = (axis_sum[a] < 0) ? 64'(-axis_sum[a]) : 64'(axis_sum[a]);
          nsq = {{(128-CB){1'b0}}, count} * {64'b0, axis_sq_sum[a]};
          ssq = {64'b0, mag} * {64'b0, mag};
          num = (nsq < ssq) ? 128'b0 : nsq - ssq;
          num = num << FB;
          den = {{(128-CB){1'b0}}, count} * {{(128-CB){1'b0}}, count};
          spread = num / den;
          exp_stats.mean[a]   = q[MEAN_W-1:0];
          exp_stats.spread[a] = spread[SPREAD_W-1:0];
        end
      end
      exp_stats.total     = count;
      exp_stats.saturated = full;
      pending_stats.push_back(exp_stats);
    endfunction

    task log_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    // compare one result with the oldest expected statistics
    task match_stats(logic [OUT_W-1:0] data, logic sat);
      stats_t got;
      stats_t want;
      for (int a = 0; a < AXES; a++) begin
        got.mean[a]   = data[a*MEAN_W +: MEAN_W];
        got.spread[a] = data[SPREAD_LO + a*SPREAD_W +: SPREAD_W];
      end
      got.total     = data[TOTAL_LO +: CB];
      got.saturated = sat;
      if (pending_stats.size() == 0) begin
        log_mismatch("result with nothing outstanding, total", 64'(got.total), 64'(0));
      end else begin
        want = pending_stats.pop_front();
        matched++;
        for (int a = 0; a < AXES; a++) begin
          if (got.mean[a] !== want.mean[a]) begin
            log_mismatch($sformatf("mean axis %0d", a), 64'(got.mean[a]), 64'(want.mean[a]));
          end
          if (got.spread[a] !== want.spread[a]) begin
            log_mismatch($sformatf("spread axis %0d", a), 64'(got.spread[a]),
                         64'(want.spread[a]));
          end
        end
        if (got.total !== want.total) begin
          log_mismatch("sample_total", 64'(got.total), 64'(want.total));
        end
        if (got.saturated !== want.saturated) begin
          log_mismatch("saturated", 64'(got.saturated), 64'(want.saturated));
        end
      end
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;

  moment_tracker tracker = new();

  bit idle_en;        // random idling on both sides
  bit hold_off_req;   // asks the receiver for one long hold-off
  int samples_in;
  int quiet_cycles;

  running_mean_variance_3axis u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // request and result handshakes seen at the edge; requests are folded in first
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      tracker.fold_sample(in_tdata);
      samples_in++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      tracker.match_stats(out_tdata, out_tuser);
    end
  end

  // watchdog: cycles in which neither side moves anything
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // offer one request, with a random gap in front when idling is on
  task send_sample(logic signed [SB-1:0] x, logic signed [SB-1:0] y,
                   logic signed [SB-1:0] z);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({z, y, x});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // one random value for an axis, shaped like sensor data in most cases
  function logic [SB-1:0] pick_value(int mode, logic [SB-1:0] center);
    logic [SB-1:0] v;
    case (mode)
      0: v = SB'($urandom);
      1: v = SB'($urandom_range(0, 600) - 300);
      2: begin
        case ($urandom_range(0, 3))
          0: v = {1'b1, {(SB-1){1'b0}}};
          1: v = {1'b0, {(SB-1){1'b1}}};
          2: v = '1;
          default: v = '0;
        endcase
      end
      default: v = center + SB'($urandom_range(0, 64) - 32);
    endcase
    return v;
  endfunction

  initial begin
    logic [SB-1:0] mx;
    logic [SB-1:0] mn;
    logic [SB-1:0] cx;
    logic [SB-1:0] cy;
    logic [SB-1:0] cz;
    int mode;
    mx = {1'b0, {(SB-1){1'b1}}};
    mn = {1'b1, {(SB-1){1'b0}}};
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    idle_en      = 1'b1;
    hold_off_req = 1'b0;
    samples_in   = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero, extremes, signs mixed across axes, alternating extremes
    // for the largest spread, and near-zero values whose mean truncates toward zero
    send_sample('0, '0, '0);
    send_sample(mx, mx, mx);
    send_sample(mn, mn, mn);
    send_sample(mx, mn, '0);
    send_sample(mn, mx, '1);
    send_sample('1, SB'(1), '1);
    send_sample(SB'(1), '1, '0);
    send_sample(mn, mn, mx);
    send_sample(mx, mx, mn);
    send_sample(mn, mx, mn);
    send_sample(mx, mn, mx);
    send_sample('1, '1, '1);
    send_sample(SB'(-3), SB'(3), SB'(-7));
    send_sample(SB'(16384), SB'(-16384), SB'(255));
    send_sample(SB'(12345), SB'(-23456), SB'(32000));
    send_sample('0, mx, mn);

    // random: sensor-like samples around a drifting offset, plus noise and extremes;
    // the full-count path needs 2^24 samples and is beyond this run
    cx = SB'($urandom);
    cy = SB'($urandom);
    cz = SB'($urandom);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 120) begin
        hold_off_req = 1'b1;
      end
      // a stretch with no idling, and none at the end
      idle_en = !((i >= 200 && i < 260) || i >= RANDOM_ITEMS - 40);
      if ($urandom_range(0, 49) == 0) begin
        cx = SB'($urandom);
        cy = SB'($urandom);
        cz = SB'($urandom);
      end
      mode = $urandom_range(0, 9);
      mode = (mode < 5) ? 3 : (mode < 7) ? 0 : (mode < 9) ? 1 : 2;
      send_sample(pick_value(mode, cx), pick_value(mode, cy), pick_value(mode, cz));
    end
    in_tvalid <= 1'b0;

    // drain, then let any late result show up
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d samples and %0d checked results, incl. extremes and a %0d-cycle",
             samples_in, tracker.matched, HOLD_CYCLES);
    $display("receiver hold-off; %0d mismatches, %0d results still outstanding",
             tracker.mismatches, tracker.pending());
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/rmv_pkg.sv
hw/rtl/rmv_mul.sv
hw/rtl/rmv_div.sv
hw/rtl/rmv_datapath.sv
hw/rtl/rmv_ctrl.sv
hw/rtl/running_mean_variance_3axis.sv
tb/testbench.sv
